@@ rtl/core/bpdc_pkg.sv @@
package bpdc_pkg;

  localparam int BUTTON_W = 3;
  localparam int STAMP_W  = 32;
  localparam int THR_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_SHORT  = 2'd1,
    CLS_MEDIUM = 2'd2,
    CLS_LONG   = 2'd3
  } press_class_t;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN   = 2'd3;

  localparam logic [THR_W-1:0] RST_SHORT_MIN  = 16'd60;
  localparam logic [THR_W-1:0] RST_SHORT_MAX  = 16'd400;
  localparam logic [THR_W-1:0] RST_MEDIUM_MIN = 16'd3000;
  localparam logic [THR_W-1:0] RST_LONG_MIN   = 16'd5000;

  typedef struct packed {
    logic               level;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam entry_t ENTRY_RST = '{level: 1'b1, stamp: '0};

  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic [THR_W-1:0] short_min;
    logic [THR_W-1:0] short_max;
    logic [THR_W-1:0] medium_min;
    logic [THR_W-1:0] long_min;
  } thresh_t;

endpackage

@@ rtl/core/button_press_duration_classifier.sv @@
// Button press duration classifier.
// Input channel (in_valid/in_ready): one pin event per transfer, carrying the
// button index, the sampled level (0 pressed, 1 released) and a millisecond
// time stamp. Events for an index at or above NUM_BUTTONS are taken and dropped.
// Output channel (out_valid/out_ready): one transfer per level change, with the
// button, the new level, and on a rising edge the held time (modulo 2^32) and
// its class: none, short, medium or long. Unchanged levels produce nothing.
// Configuration: cfg_we writes cfg_wdata into threshold cfg_index at once.
// Throughput: one event per cycle unless the output stalls. Per-button level and edge
// time sit in a one-read one-write entry RAM with a registered read; a forwarding
// register covers back-to-back same-button hits on the read-modify-write of an entry.
// Stages: a result passes the lookup stage, the measure stage and the result register.
// Reset: all buttons read as released with edge time 0 from the first cycle
// after reset (per-entry valid flags, no clearing pass); thresholds return to
// 60, 400, 3000 and 5000 ms.
// When out_ready is low and a result is waiting the pipeline holds; up to three events are in flight
// and in_ready drops only once every stage is full.
module button_press_duration_classifier
  import bpdc_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BUTTON_W-1:0]  in_button_index,
  input  logic                 in_pin_level,
  input  logic [STAMP_W-1:0]   in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BUTTON_W-1:0]  out_event_button,
  output logic                 out_new_level,
  output logic [1:0]           out_press_class,
  output logic [STAMP_W-1:0]   out_held_ms,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_wdata
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int XW = (AW > BUTTON_W) ? AW : BUTTON_W;

  thresh_t thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_min  <= RST_SHORT_MIN;
      thr_r.short_max  <= RST_SHORT_MAX;
      thr_r.medium_min <= RST_MEDIUM_MIN;
      thr_r.long_min   <= RST_LONG_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_MIN:  thr_r.short_min  <= cfg_wdata;
        REG_SHORT_MAX:  thr_r.short_max  <= cfg_wdata;
        REG_MEDIUM_MIN: thr_r.medium_min <= cfg_wdata;
        REG_LONG_MIN:   thr_r.long_min   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // index check and RAM address
  logic [XW-1:0] idx_ext;
  logic          in_known;
  logic          in_fire;
  logic          rd_en;

  assign idx_ext  = XW'(in_button_index);
  assign in_known = {1'b0, idx_ext} < (XW + 1)'(NUM_BUTTONS);
  assign in_fire  = in_valid && in_ready;
  assign rd_en    = in_fire && in_known;

  // lookup stage
  logic                s1_vld_r, s1_vld_nxt;
  logic [BUTTON_W-1:0] s1_button_r;
  logic                s1_level_r;
  logic [STAMP_W-1:0]  s1_now_r;
  logic                s1_emit;
  logic                s1_go;
  entry_t              cur;
  wr_req_t             wr;

  // measure stage
  logic                s2_vld_r, s2_vld_nxt;
  logic [BUTTON_W-1:0] s2_button_r;
  logic                s2_level_r;
  logic [STAMP_W-1:0]  s2_held_r;
  logic                s2_go;
  logic                s2_ready;
  press_class_t        s2_cls;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [BUTTON_W-1:0] out_button_r;
  logic                out_level_r;
  press_class_t        out_cls_r;
  logic [STAMP_W-1:0]  out_held_r;
  logic                out_free;

  bpdc_entry_store #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (idx_ext[AW-1:0]),
    .wr      (wr),
    .rd_entry(cur)
  );

  bpdc_classify u_classify (
    .held(s2_held_r),
    .thr (thr_r),
    .cls (s2_cls)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_vld_r && out_free;
  assign s2_ready = !s2_vld_r || s2_go;
  assign s1_emit  = s1_vld_r && (s1_level_r != cur.level);
  assign s1_go    = s1_vld_r && (!s1_emit || s2_ready);
  assign in_ready = !s1_vld_r || s1_go;

  assign wr.en         = s1_emit && s1_go;
  assign wr.data.level = s1_level_r;
  assign wr.data.stamp = s1_now_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (rd_en) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
    s2_vld_nxt = s2_vld_r;
    if (wr.en) begin
      s2_vld_nxt = 1'b1;
    end else if (s2_go) begin
      s2_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_button_r <= in_button_index;
      s1_level_r  <= in_pin_level;
      s1_now_r    <= in_now_ms;
    end
    if (wr.en) begin
      s2_button_r <= s1_button_r;
      s2_level_r  <= s1_level_r;
      s2_held_r   <= s1_level_r ? (s1_now_r - cur.stamp) : '0;
    end
    if (s2_go) begin
      out_button_r <= s2_button_r;
      out_level_r  <= s2_level_r;
      out_cls_r    <= s2_level_r ? s2_cls : CLS_NONE;
      out_held_r   <= s2_held_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_button = out_button_r;
  assign out_new_level    = out_level_r;
  assign out_press_class  = out_cls_r;
  assign out_held_ms      = out_held_r;

`ifndef SYNTH
  a_fall_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_new_level |-> out_held_ms == '0 && out_press_class == CLS_NONE)
    else $error("falling edge result carries held time or class");

  a_long_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_class == CLS_LONG
      |-> out_held_ms >= STAMP_W'(thr_r.long_min))
    else $error("long class below threshold");

  a_unknown_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_known |=> !s1_vld_r)
    else $error("unknown button entered lookup stage");
`endif

endmodule

@@ rtl/core/bpdc_entry_store.sv @@
module bpdc_entry_store
  import bpdc_pkg::*;
#(
  parameter int NUM_BUTTONS = 8,
  parameter int AW = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  wr_req_t       wr,
  output entry_t        rd_entry
);

  entry_t                 mem [NUM_BUTTONS];
  entry_t                 rd_q_r;
  entry_t                 fwd_data_r;
  logic                   fwd_hit_r;
  logic [AW-1:0]          addr_r;
  logic [NUM_BUTTONS-1:0] vld_r;

  // write always targets the entry of the item currently being looked up
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[addr_r] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r     <= rd_addr;
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit_r <= wr.en && (addr_r == rd_addr);
      end
    end
  end

  // same-entry write in the lookup cycle bypasses the stale read
  always_comb begin
    if (fwd_hit_r) begin
      rd_entry = fwd_data_r;
    end else if (vld_r[addr_r]) begin
      rd_entry = rd_q_r;
    end else begin
      rd_entry = ENTRY_RST;
    end
  end

endmodule

@@ rtl/core/bpdc_classify.sv @@
module bpdc_classify
  import bpdc_pkg::*;
(
  input  logic [STAMP_W-1:0] held,
  input  thresh_t            thr,
  output press_class_t       cls
);

  logic [STAMP_W-1:0] short_min;
  logic [STAMP_W-1:0] short_max;
  logic [STAMP_W-1:0] medium_min;
  logic [STAMP_W-1:0] long_min;

  assign short_min  = STAMP_W'(thr.short_min);
  assign short_max  = STAMP_W'(thr.short_max);
  assign medium_min = STAMP_W'(thr.medium_min);
  assign long_min   = STAMP_W'(thr.long_min);

  always_comb begin
    if (held > short_min && held < short_max) begin
      cls = CLS_SHORT;
    end else if (held > medium_min && held < long_min) begin
      cls = CLS_MEDIUM;
    end else if (held >= long_min) begin
      cls = CLS_LONG;
    end else begin
      cls = CLS_NONE;
    end
  end

endmodule
